@@ src/lfsr_payload_descrambler_core_defines.svh @@
// Assertion macros for the payload descrambler.
// Used by lfsr_payload_descrambler_core only; no other dependencies.
`ifndef LFSR_PAYLOAD_DESCRAMBLER_CORE_DEFINES_SVH
`define LFSR_PAYLOAD_DESCRAMBLER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lpd_pkg.sv @@
// Shared types, constants and the LFSR step function for the payload descrambler.
// No dependencies; used by every module of the block.
package lpd_pkg;

  // Telegram layout
  localparam int unsigned HEADER_BYTES = 15;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES + 1);

  localparam logic [POS_W-1:0] POS_HEADER       = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_GATHER_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0] POS_GATHER_LAST  = POS_W'(13);
  localparam logic [POS_W-1:0] POS_WORD_A       = POS_W'(5);
  localparam logic [POS_W-1:0] POS_WORD_B       = POS_W'(9);
  localparam logic [POS_W-1:0] POS_WORD_C       = POS_W'(13);
  localparam logic [POS_W-1:0] POS_CHECK        = POS_W'(HEADER_BYTES - 1);

  // Byte constants
  localparam logic [7:0] CHECK_MASK      = 8'hEF;
  localparam logic [7:0] FIRST_BYTE_WANT = 8'h4B;

  // Configuration register indexes
  localparam logic [0:0] REG_BASE_KEY   = 1'b0;
  localparam logic [0:0] REG_CHECK_MODE = 1'b1;

  // Check modes (code 3 acts as no check)
  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_FIRST_BYTE = 2'd1;
  localparam logic [1:0] MODE_CHECKSUM   = 2'd2;
  localparam logic [1:0] MODE_RESET      = MODE_CHECKSUM;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_CHECK_BYTE = 2'd1,
    STATUS_CHECKSUM   = 2'd2,
    STATUS_SHORT      = 2'd3
  } status_e;

  // Command word from the front part to the back part
  typedef struct packed {
    logic [7:0]  data;
    logic        payload;  // byte is a payload byte
    logic        last;     // byte ends the telegram
    logic        fresh;    // first command of its telegram
    logic [31:0] seed;     // LFSR seed, used when fresh
    logic [7:0]  check;    // masked check value
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [7:0] plain;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } res_t;

  // Advance the LFSR by eight steps: shift left, feedback from bits 1, 2, 11, 31.
  function automatic logic [31:0] clock_eight(input logic [31:0] w_in);
    logic [31:0] w;
    logic        fb;
    w = w_in;
    for (int k = 0; k < 8; k++) begin
      fb = w[1] ^ w[2] ^ w[11] ^ w[31];
      w  = {w[30:0], fb};
    end
    return w;
  endfunction

endpackage

@@ src/lpd_front.sv @@
// Front part: tracks byte position, builds the LFSR seed and the check value
// from the header, and issues one command word per payload or last byte. Uses lpd_pkg.
module lpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        base_key_i,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  input  logic               frame_end_i,
  output logic               cmd_push_o,
  output lpd_pkg::cmd_t      cmd_o
);

  logic [lpd_pkg::POS_W-1:0] pos_q, pos_d, pos_eff;
  logic                      fresh_q, fresh_d, fresh_base;
  logic [31:0]               gather_q, gather_d, gather_base;
  logic [31:0]               seed_q, seed_d, seed_base;
  logic [7:0]                check_q, check_d, check_base;
  logic                      start;
  logic                      is_header;

  // Classify the byte and update header state
  always_comb begin
    start       = frame_start_i || (pos_q == '0);
    pos_eff     = start ? '0 : pos_q;
    gather_base = start ? '0 : gather_q;
    seed_base   = start ? base_key_i : seed_q;
    check_base  = start ? '0 : check_q;
    fresh_base  = start | fresh_q;
    is_header   = pos_eff < lpd_pkg::POS_HEADER;

    pos_d    = pos_q;
    fresh_d  = fresh_q;
    gather_d = gather_q;
    seed_d   = seed_q;
    check_d  = check_q;

    cmd_push_o = accept_i && (!is_header || frame_end_i);

    if (accept_i) begin
      gather_d = gather_base;
      seed_d   = seed_base;
      check_d  = check_base;
      pos_d    = pos_eff;
      if (is_header) begin
        if (pos_eff >= lpd_pkg::POS_GATHER_FIRST && pos_eff <= lpd_pkg::POS_GATHER_LAST) begin
          gather_d = {gather_base[23:0], data_byte_i};
          if (pos_eff inside {lpd_pkg::POS_WORD_A, lpd_pkg::POS_WORD_B,
                              lpd_pkg::POS_WORD_C}) begin
            seed_d = seed_base ^ gather_d;
          end
        end
        if (pos_eff == lpd_pkg::POS_CHECK) begin
          check_d = data_byte_i & lpd_pkg::CHECK_MASK;
        end
        pos_d = pos_eff + 1'b1;
      end
      if (frame_end_i) begin
        pos_d = '0;
      end
      fresh_d = cmd_push_o ? 1'b0 : fresh_base;
    end
  end

  // Build the command word
  always_comb begin
    cmd_o.data    = data_byte_i;
    cmd_o.payload = !is_header;
    cmd_o.last    = frame_end_i;
    cmd_o.fresh   = fresh_base;
    cmd_o.seed    = seed_base;
    cmd_o.check   = check_base;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fresh_q <= fresh_d;
    end
  end

  // Header data, loaded at telegram start before use
  always_ff @(posedge clk_i) begin
    gather_q <= gather_d;
    seed_q   <= seed_d;
    check_q  <= check_d;
  end

endmodule

@@ src/lpd_cmd_queue.sv @@
// Two-entry command queue between the front and back parts.
// Uses lpd_pkg for the command word type.
module lpd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lpd_pkg::cmd_t data_o
);

  lpd_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  // Occupancy and pointers
  always_comb begin
    full_o   = count_q == 2'd2;
    valid_o  = count_q != 2'd0;
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
    data_o   = entry_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/lpd_back.sv @@
// Back part: runs the LFSR, descrambles payload bytes, keeps the sum and the
// check outcome, and queues result words for the output. Uses lpd_pkg.
module lpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    check_mode_i,
  input  logic          cmd_valid_i,
  input  lpd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lpd_pkg::res_t res_o
);

  logic [31:0]      lfsr_q, lfsr_d, lfsr_base, lfsr_next;
  logic [7:0]       sum_q, sum_d, sum_base;
  logic             seen_q, seen_d, seen_base;
  logic [1:0]       fail_q, fail_d, fail_base;
  logic [7:0]       plain;
  lpd_pkg::status_e status;
  lpd_pkg::res_t    res_new;

  lpd_pkg::res_t    res_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             res_full, do_pop;

  // Take a command when the result queue has room
  assign res_full  = count_q == 2'd2;
  assign cmd_pop_o = cmd_valid_i && !res_full;

  // Descramble and evaluate the checks
  always_comb begin
    lfsr_base = cmd_i.fresh ? cmd_i.seed : lfsr_q;
    sum_base  = cmd_i.fresh ? 8'd0 : sum_q;
    seen_base = cmd_i.fresh ? 1'b0 : seen_q;
    fail_base = cmd_i.fresh ? 2'(lpd_pkg::STATUS_OK) : fail_q;

    lfsr_next = lpd_pkg::clock_eight(lfsr_base);
    plain     = cmd_i.data ^ lfsr_next[7:0];

    lfsr_d = lfsr_base;
    sum_d  = sum_base;
    seen_d = seen_base;
    fail_d = fail_base;

    if (cmd_i.payload) begin
      lfsr_d = lfsr_next;
      sum_d  = sum_base + plain;
      if (!seen_base && check_mode_i == lpd_pkg::MODE_FIRST_BYTE &&
          plain != lpd_pkg::FIRST_BYTE_WANT) begin
        fail_d = 2'(lpd_pkg::STATUS_CHECK_BYTE);
      end
      seen_d = 1'b1;
    end

    status = lpd_pkg::status_e'(fail_d);
    if (cmd_i.last) begin
      if (!seen_d) begin
        status = lpd_pkg::STATUS_SHORT;
      end else begin
        case (check_mode_i)
          lpd_pkg::MODE_CHECKSUM: begin
            status = ((sum_d & lpd_pkg::CHECK_MASK) != cmd_i.check) ?
                     lpd_pkg::STATUS_CHECKSUM : lpd_pkg::STATUS_OK;
          end
          lpd_pkg::MODE_FIRST_BYTE: begin
            status = lpd_pkg::status_e'(fail_d);
          end
          default: begin
            status = lpd_pkg::STATUS_OK;
          end
        endcase
      end
      fail_d = status;
    end

    res_new.plain  = cmd_i.payload ? plain : 8'd0;
    res_new.valid  = cmd_i.payload;
    res_new.last   = cmd_i.last;
    res_new.status = status;
  end

  // Control state of the telegram
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      fail_q <= 2'(lpd_pkg::STATUS_OK);
    end else if (cmd_pop_o) begin
      seen_q <= seen_d;
      fail_q <= fail_d;
    end
  end

  // LFSR and sum, reloaded at each telegram start
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      lfsr_q <= lfsr_d;
      sum_q  <= sum_d;
    end
  end

  // Result queue: hold words until popped
  assign empty_o = count_q == 2'd0;
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = res_q[rd_ptr_q];
  assign count_d = count_q + {1'b0, cmd_pop_o} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ cmd_pop_o;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

@@ src/lfsr_payload_descrambler_core.sv @@
// Top level of the LFSR payload descrambler: configuration registers, front
// part, command queue and back part. Uses lpd_pkg and the assertion macro header.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+----------------------------------
//   input    | in        | push / full              | data_byte, frame_start, frame_end
//   result   | out       | empty / pop              | plain_byte, byte_valid,
//            |           |                          | end_of_frame, status
//   config   | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while full is low; each result word is registered
// in the command queue and then in the result queue before it leaves.
// The rate is set by the back part's combinational eight-step LFSR and sum update.
// Header bytes that give no result occupy no queue entry.
// Reset is asynchronous, active low, and empties both queues; full rises only
// when the two-entry command queue is full because pop is held low.
`include "lfsr_payload_descrambler_core_defines.svh"

module lfsr_payload_descrambler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        frame_end_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  plain_byte_o,
  output logic        byte_valid_o,
  output logic        end_of_frame_o,
  output logic [1:0]  status_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]   base_key_q;
  logic [1:0]    check_mode_q;
  logic          in_accept;
  logic          cmd_push, cmd_full, cmd_valid, cmd_pop;
  lpd_pkg::cmd_t cmd_in, cmd_out;
  lpd_pkg::res_t res;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_key_q   <= '0;
      check_mode_q <= lpd_pkg::MODE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lpd_pkg::REG_BASE_KEY:   base_key_q   <= cfg_data_i;
        lpd_pkg::REG_CHECK_MODE: check_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Accept a word whenever the command queue has room
  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  lpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_key_i    (base_key_q),
    .accept_i      (in_accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .frame_end_i   (frame_end_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  lpd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  lpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .check_mode_i (check_mode_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  // Drive the result ports
  assign plain_byte_o   = res.plain;
  assign byte_valid_o   = res.valid;
  assign end_of_frame_o = res.last;
  assign status_o       = res.status;

  // Assertions
  `LPD_ASSERT(a_plain_zero_when_no_byte, clk_i, rst_ni, (!empty && !byte_valid_o) |-> (plain_byte_o == 8'd0), "plain byte not zero on a result without payload byte")
  `LPD_ASSERT(a_short_only_at_end, clk_i, rst_ni, (!empty && status_o == 2'(lpd_pkg::STATUS_SHORT)) |-> (end_of_frame_o && !byte_valid_o), "too-short status on a result that is not a bare last word")
  `LPD_ASSERT(a_mid_status, clk_i, rst_ni, (!empty && !end_of_frame_o) |-> (byte_valid_o && (status_o == 2'(lpd_pkg::STATUS_OK) || status_o == 2'(lpd_pkg::STATUS_CHECK_BYTE))), "bad result before the last byte")
  `LPD_ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni) |-> (empty && !full), "queues not empty in reset")

endmodule

@@ tb/lfsr_payload_descrambler_core_tb.sv @@
// Self-checking testbench for lfsr_payload_descrambler_core: directed telegrams, check modes,
// mode changes inside a telegram and random traffic under back-pressure.
// Depends on lpd_pkg and the core RTL only.
module lfsr_payload_descrambler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET   = 1700;
  localparam int          PHASE_ITEMS   = 140;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [31:0] LFSR_TAPS     = 32'h8000_0806;  // bits 31, 11, 2, 1

  // One raw telegram byte with its framing flags
  typedef struct {
    logic [7:0] data;
    logic       st;
    logic       en;
  } raw_byte_t;

  // One descrambled result word
  typedef struct packed {
    logic [7:0]       plain;
    logic             valid;
    logic             last;
    lpd_pkg::status_e status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        frame_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  plain_byte;
  logic        byte_valid;
  logic        end_of_frame;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = lpd_pkg::REG_BASE_KEY;
  logic [31:0] cfg_data = 32'h0;

  // Descrambler shadow state
  logic [31:0]      key_q = 32'h0;
  logic [1:0]       mode_q = lpd_pkg::MODE_RESET;
  logic [3:0]       pos_q = 4'd0;
  logic [31:0]      lfsr_q = 32'h0;
  logic [7:0]       sum_q = 8'h0;
  logic [7:0]       chk_q = 8'h0;
  logic [31:0]      gather_q = 32'h0;
  lpd_pkg::status_e fail_q = lpd_pkg::STATUS_OK;
  bit               seen_q = 1'b0;

  result_t     due_results_q[$];
  raw_byte_t   telegram_q[$];
  int          items_sent = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  lfsr_payload_descrambler_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte),
    .frame_start_i  (frame_start),
    .frame_end_i    (frame_end),
    .empty          (empty),
    .pop            (pop),
    .plain_byte_o   (plain_byte),
    .byte_valid_o   (byte_valid),
    .end_of_frame_o (end_of_frame),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clock the LFSR eight steps, new bit in at the bottom
  function automatic logic [31:0] lfsr_advance8(input logic [31:0] w_in);
    logic [31:0] w;
    int          k;
    w = w_in;
    for (k = 0; k < 8; k++) begin
      w = {w[30:0], ^(w & LFSR_TAPS)};
    end
    return w;
  endfunction

  // Advance the shadow state by one raw byte; return 1 when a word comes out
  function automatic bit descramble_byte(input logic [7:0] d, input logic st, input logic en,
                                         output result_t r);
    logic [3:0]       p;
    logic [7:0]       plain;
    bit               emit;
    lpd_pkg::status_e stat;
    plain = 8'h00;
    emit  = 1'b0;
    if (st || pos_q == 4'd0) begin
      pos_q    = 4'd0;
      lfsr_q   = key_q;
      sum_q    = 8'h00;
      chk_q    = 8'h00;
      gather_q = 32'h0;
      fail_q   = lpd_pkg::STATUS_OK;
      seen_q   = 1'b0;
    end
    p = pos_q;
    if (p < lpd_pkg::HEADER_BYTES) begin
      if (p >= lpd_pkg::POS_GATHER_FIRST && p <= lpd_pkg::POS_GATHER_LAST) begin
        gather_q = {gather_q[23:0], d};
        if (p == lpd_pkg::POS_WORD_A || p == lpd_pkg::POS_WORD_B ||
            p == lpd_pkg::POS_WORD_C) lfsr_q ^= gather_q;
      end
      if (p == lpd_pkg::POS_CHECK) chk_q = d & lpd_pkg::CHECK_MASK;
      pos_q = p + 4'd1;
    end else begin
      lfsr_q = lfsr_advance8(lfsr_q);
      plain  = d ^ lfsr_q[7:0];
      sum_q  = sum_q + plain;
      if (!seen_q && mode_q == lpd_pkg::MODE_FIRST_BYTE &&
          plain != lpd_pkg::FIRST_BYTE_WANT) begin
        fail_q = lpd_pkg::STATUS_CHECK_BYTE;
      end
      seen_q = 1'b1;
      emit   = 1'b1;
    end
    stat = fail_q;
    if (en) begin
      if (!seen_q) stat = lpd_pkg::STATUS_SHORT;
      else if (mode_q == lpd_pkg::MODE_CHECKSUM)
        stat = ((sum_q & lpd_pkg::CHECK_MASK) != chk_q) ? lpd_pkg::STATUS_CHECKSUM
                                                         : lpd_pkg::STATUS_OK;
      else if (mode_q == lpd_pkg::MODE_FIRST_BYTE) stat = fail_q;
      else stat = lpd_pkg::STATUS_OK;
      fail_q = stat;
      pos_q  = 4'd0;
      emit   = 1'b1;
    end
    r.plain  = plain;
    r.valid  = seen_q && (p >= lpd_pkg::HEADER_BYTES);
    r.last   = en;
    r.status = stat;
    return emit;
  endfunction

  // Build a telegram in telegram_q; a good one passes both checks under the current key
  task automatic make_telegram(input int n_pay, input bit good, input bit with_start,
                               input bit with_end, input int cut_len);
    logic [7:0]  hdr[15];
    logic [7:0]  plain_b[$];
    logic [31:0] w;
    logic [31:0] gat;
    logic [7:0]  s;
    logic [7:0]  pb;
    raw_byte_t   rb;
    int          i;
    int          total;
    w   = key_q;
    gat = 32'h0;
    s   = 8'h00;
    for (i = 0; i < 14; i++) hdr[i] = 8'($urandom);
    for (i = lpd_pkg::POS_GATHER_FIRST; i <= lpd_pkg::POS_GATHER_LAST; i++) begin
      gat = {gat[23:0], hdr[i]};
      if (i == lpd_pkg::POS_WORD_A || i == lpd_pkg::POS_WORD_B ||
          i == lpd_pkg::POS_WORD_C) w ^= gat;
    end
    for (i = 0; i < n_pay; i++) begin
      pb = 8'($urandom);
      if (i == 0 && good) pb = lpd_pkg::FIRST_BYTE_WANT;
      plain_b = {plain_b, pb};
      s = s + pb;
    end
    hdr[14] = good ? ((s & lpd_pkg::CHECK_MASK) | (8'($urandom) & ~lpd_pkg::CHECK_MASK))
                   : 8'($urandom);
    total = lpd_pkg::HEADER_BYTES + n_pay;
    if (cut_len > 0 && cut_len < total) total = cut_len;
    for (i = 0; i < total; i++) begin
      if (i < lpd_pkg::HEADER_BYTES) begin
        rb.data = hdr[i];
      end else begin
        w       = lfsr_advance8(w);
        rb.data = plain_b[i - lpd_pkg::HEADER_BYTES] ^ w[7:0];
      end
      rb.st = with_start && (i == 0);
      rb.en = with_end && (i == total - 1);
      telegram_q = {telegram_q, rb};
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it, and predict on acceptance
  task automatic send_raw(input raw_byte_t rb);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push      <= 1'b0;
      data_byte <= 8'($urandom);
      @(posedge clk);
    end
    push        <= 1'b1;
    data_byte   <= rb.data;
    frame_start <= rb.st;
    frame_end   <= rb.en;
    @(posedge clk);
    while (full) @(posedge clk);
    if (descramble_byte(rb.data, rb.st, rb.en, r)) due_results_q = {due_results_q, r};
    items_sent++;
  endtask

  task automatic send_bytes(input int count);
    int k;
    for (k = 0; k < count && telegram_q.size() != 0; k++) send_raw(telegram_q.pop_front());
  endtask

  // Hold off input until every predicted word has come out and the pipe is quiet
  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk);
    while (due_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; upper data bits of the mode word are don't-care
  task automatic write_config(input logic [31:0] key, input logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_index <= lpd_pkg::REG_BASE_KEY;
    cfg_data  <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_q = key;
    cfg_index <= lpd_pkg::REG_CHECK_MODE;
    cfg_data  <= {30'($urandom), mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_q = mode;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Reset values of the registers, one-byte and headless telegrams, restart mid-header
  task automatic test_reset_defaults();
    raw_byte_t rb;
    set_idling(0);
    rb = '{data: 8'hFF, st: 1'b1, en: 1'b1};
    send_raw(rb);
    rb = '{data: 8'h00, st: 1'b0, en: 1'b1};
    send_raw(rb);
    make_telegram(1, 1'b1, 1'b1, 1'b0, 4);
    make_telegram(1, 1'b1, 1'b1, 1'b1, 0);
    send_bytes(telegram_q.size());
    wait_results_drained();
  endtask

  // Each check mode with passing and failing telegrams, extreme keys among them
  task automatic test_check_modes();
    logic [31:0] keys[4];
    int          m;
    int          t;
    keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), 32'($urandom)};
    for (m = 0; m < 4; m++) begin
      set_idling(m);
      write_config(keys[m], 2'(m));
      for (t = 0; t < 5; t++) begin
        make_telegram($urandom_range(1, 6), t < 3, 1'b1, 1'b1, 0);
        send_bytes(telegram_q.size());
      end
      wait_results_drained();
    end
  endtask

  // Rewrite key and mode while a telegram is open; the new mode rules the remaining bytes
  task automatic test_mode_change_midframe();
    int k;
    for (k = 0; k < 6; k++) begin
      set_idling(k);
      write_config(32'($urandom), 2'($urandom_range(0, 3)));
      make_telegram(6, $urandom_range(0, 1), 1'b1, 1'b1, 0);
      send_bytes($urandom_range(13, 18));
      wait_results_drained();
      write_config(32'($urandom), 2'($urandom_range(0, 3)));
      send_bytes(telegram_q.size());
      wait_results_drained();
    end
  endtask

  // Mostly well-formed telegrams with random content; the rest noise and broken framing
  task automatic test_random_traffic();
    int          ph;
    int          start_items;
    int          pick;
    int          n_pay;
    int          k;
    logic [31:0] key;
    raw_byte_t   rb;
    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_results_drained();
      set_idling(ph);
      case (ph % 5)
        0: key = 32'h0000_0000;
        1: key = 32'hFFFF_FFFF;
        default: key = 32'($urandom);
      endcase
      write_config(key, 2'($urandom_range(0, 3)));
      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS) begin
        pick  = $urandom_range(99);
        n_pay = ($urandom_range(99) < 5) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        if (pick < 70) begin
          make_telegram(n_pay, 1'b1, $urandom_range(99) < 90, 1'b1, 0);
        end else if (pick < 80) begin
          make_telegram(n_pay, 1'b0, 1'b1, 1'b1, 0);
        end else if (pick < 88) begin
          make_telegram(n_pay, $urandom_range(0, 1), $urandom_range(0, 1), 1'b1,
                        $urandom_range(1, lpd_pkg::HEADER_BYTES));
        end else if (pick < 94) begin
          make_telegram(n_pay, 1'b1, 1'b1, 1'b0, 0);
        end else begin
          for (k = 0; k < $urandom_range(1, 6); k++) begin
            rb.data = 8'($urandom);
            rb.st   = $urandom_range(99) < 15;
            rb.en   = $urandom_range(99) < 15;
            telegram_q = {telegram_q, rb};
          end
        end
        send_bytes(telegram_q.size());
      end
      ph++;
    end
  endtask

  // Randomly stall the result side and compare each popped word with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && pop && !empty) begin
      if (due_results_q.size() == 0) begin
        $error("unexpected word: plain_byte %02h byte_valid %0d end_of_frame %0d status %0d",
               plain_byte, byte_valid, end_of_frame, status);
        mismatches++;
      end else begin
        want = due_results_q.pop_front();
        if (plain_byte !== want.plain) begin
          $error("plain_byte: expected %02h, got %02h", want.plain, plain_byte);
          mismatches++;
        end
        if (byte_valid !== want.valid) begin
          $error("byte_valid: expected %0d, got %0d", want.valid, byte_valid);
          mismatches++;
        end
        if (end_of_frame !== want.last) begin
          $error("end_of_frame: expected %0d, got %0d", want.last, end_of_frame);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Assert reset with a real falling edge so the asynchronous reset takes hold at once
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_check_modes();
    test_mode_change_midframe();
    test_random_traffic();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
